[rtl/adaptive_slicer_bit_packer_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive slicer bit packer
// Shared property wrappers; every property is clocked on clk and is
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_SLICER_BIT_PACKER_CORE_MACROS_SVH
`define ADAPTIVE_SLICER_BIT_PACKER_CORE_MACROS_SVH

// Same-cycle implication.
`define ASBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/asbp_pkg.sv]
// ---------------------------------------------------------------------------
// Adaptive slicer bit packer package
// Register indexes, field widths, configuration bundle and helpers.
// ---------------------------------------------------------------------------
package asbp_pkg;

  localparam int SampleW = 10;
  localparam int ByteW   = 8;
  localparam int ShiftW  = 4;
  localparam int HystW   = 8;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 8;
  // Signed working width for differences and sums of 10-bit levels.
  localparam int WorkW   = 13;

  localparam logic [SampleW-1:0] Midscale = 10'd512;
  localparam logic [SampleW-1:0] SampleMax = 10'd1023;

  localparam logic [CfgAddrW-1:0] RegAdaptiveMode  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegFilterShift   = 3'd1;
  localparam logic [CfgAddrW-1:0] RegEnvelopeShift = 3'd2;
  localparam logic [CfgAddrW-1:0] RegCenterShift   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegMinHyst       = 3'd4;
  localparam logic [CfgAddrW-1:0] RegMaxHyst       = 3'd5;

  typedef logic signed [WorkW-1:0] work_t;

  typedef struct packed {
    logic              adaptive_mode;
    logic [ShiftW-1:0] filter_shift;
    logic [ShiftW-1:0] envelope_shift;
    logic [ShiftW-1:0] center_shift;
    logic [HystW-1:0]  min_hysteresis;
    logic [HystW-1:0]  max_hysteresis;
  } cfg_t;

  typedef struct packed {
    logic last_bit;  // the pending bit completes a byte
    logic out_free;  // the result register can take a byte this cycle
  } pk_stat_t;

  function automatic work_t widen(input logic [SampleW-1:0] v);
    widen = $signed({3'b000, v});
  endfunction

  function automatic logic [SampleW-1:0] clamp10(input work_t v);
    if (v < 0) begin
      clamp10 = '0;
    end else if (v > widen(SampleMax)) begin
      clamp10 = SampleMax;
    end else begin
      clamp10 = v[SampleW-1:0];
    end
  endfunction

endpackage

[rtl/adaptive_slicer_bit_packer_core.sv]
// A completing sample passes through the input register, then its byte is loaded into the output register.
// Throughput: one sample per cycle unless the input is blocked; the slicer's next state is combinational.
// A stalled output only blocks the input when the eighth bit of the next byte is pending.
// Reset (rst_n low, synchronous): registers return to defaults, levels to midscale,
// the packer empties and adaptive tracking waits to be primed by its first sample.
// ---------------------------------------------------------------------------
// Adaptive slicer bit packer core
// Input register, slicer and packer, output register.
// ---------------------------------------------------------------------------
`include "adaptive_slicer_bit_packer_core_macros.svh"

module adaptive_slicer_bit_packer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [9:0] sample, [15:10] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] data_byte
  input  logic                          cfg_we,
  input  logic [asbp_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [asbp_pkg::CfgDataW-1:0] cfg_wdata
);

  asbp_pkg::cfg_t               cfg_r;
  logic [asbp_pkg::SampleW-1:0] smp_r;
  logic                         s_valid_r;
  logic                         advance;
  logic                         slice_bit;
  asbp_pkg::pk_stat_t           pk_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adaptive_mode  <= 1'b0;
      cfg_r.filter_shift   <= 4'd2;
      cfg_r.envelope_shift <= 4'd6;
      cfg_r.center_shift   <= 4'd4;
      cfg_r.min_hysteresis <= 8'd4;
      cfg_r.max_hysteresis <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_addr)
        asbp_pkg::RegAdaptiveMode:  cfg_r.adaptive_mode  <= cfg_wdata[0];
        asbp_pkg::RegFilterShift:   cfg_r.filter_shift   <= cfg_wdata[3:0];
        asbp_pkg::RegEnvelopeShift: cfg_r.envelope_shift <= cfg_wdata[3:0];
        asbp_pkg::RegCenterShift:   cfg_r.center_shift   <= cfg_wdata[3:0];
        asbp_pkg::RegMinHyst:       cfg_r.min_hysteresis <= cfg_wdata;
        asbp_pkg::RegMaxHyst:       cfg_r.max_hysteresis <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The held sample is processed unless it would finish a byte while the
  // result register is still occupied.
  assign advance   = s_valid_r && (!pk_stat.last_bit || pk_stat.out_free);
  assign in_tready = !s_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      smp_r <= in_tdata[asbp_pkg::SampleW-1:0];
    end
  end

  asbp_slicer u_slicer (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .step   (advance),
    .sample (smp_r),
    .bit_o  (slice_bit)
  );

  asbp_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .bit_i      (slice_bit),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .stat       (pk_stat)
  );

  `ASBP_ASSERT_NEXT(a_stall_keeps_item, s_valid_r && !advance, s_valid_r, "held sample dropped")
  `ASBP_ASSERT_NEXT(a_byte_follows, advance && pk_stat.last_bit, out_tvalid, "byte not loaded")
  `ASBP_ASSERT_NOW(a_no_overwrite, advance && pk_stat.last_bit && out_tvalid, out_tready,
                   "pending byte overwritten")

endmodule

[rtl/asbp_slicer.sv]
// ---------------------------------------------------------------------------
// Adaptive slicer
// Low-pass filter, floor and ceiling envelopes, hysteresis and center
// tracking; turns one sample into one bit per step.
// ---------------------------------------------------------------------------
module asbp_slicer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  asbp_pkg::cfg_t               cfg,
  input  logic                         step,
  input  logic [asbp_pkg::SampleW-1:0] sample,
  output logic                         bit_o
);

  logic [asbp_pkg::SampleW-1:0] smooth_r, smooth_nxt;
  logic [asbp_pkg::SampleW-1:0] floor_r, floor_nxt;
  logic [asbp_pkg::SampleW-1:0] ceil_r, ceil_nxt;
  logic [asbp_pkg::SampleW-1:0] center_r, center_nxt;
  logic                         held_r;
  logic                         primed_r;

  asbp_pkg::work_t s_w, filt, fl, ce, span, target, ctr, delta, hy_w;
  logic [asbp_pkg::HystW-1:0] hy;
  logic                       plain_bit;

  assign plain_bit = (sample >= asbp_pkg::Midscale);

  always_comb begin
    s_w  = asbp_pkg::widen(sample);
    filt = asbp_pkg::widen(smooth_r)
         + ((s_w - asbp_pkg::widen(smooth_r)) >>> cfg.filter_shift);
    fl   = asbp_pkg::widen(floor_r);
    ce   = asbp_pkg::widen(ceil_r);
    // Envelopes jump outward at once and decay inward toward the filter.
    if (filt < fl) begin
      fl = filt;
    end else begin
      fl = fl + ((filt - fl) >>> cfg.envelope_shift);
    end
    if (filt > ce) begin
      ce = filt;
    end else begin
      ce = ce + ((filt - ce) >>> cfg.envelope_shift);
    end
    span = (ce >= fl) ? (ce - fl) : '0;
    hy   = asbp_pkg::HystW'(span[asbp_pkg::WorkW-1:7]);
    if (hy < cfg.min_hysteresis) begin
      hy = cfg.min_hysteresis;
    end
    if (hy > cfg.max_hysteresis) begin
      hy = cfg.max_hysteresis;
    end
    hy_w   = $signed({5'b00000, hy});
    target = (fl + ce) >>> 1;
    ctr    = asbp_pkg::widen(center_r)
           + ((target - asbp_pkg::widen(center_r)) >>> cfg.center_shift);
    delta  = s_w - ctr;

    smooth_nxt = asbp_pkg::clamp10(filt);
    if (!primed_r) begin
      floor_nxt  = asbp_pkg::clamp10(filt);
      ceil_nxt   = asbp_pkg::clamp10(filt);
      center_nxt = asbp_pkg::clamp10(filt);
      bit_o      = plain_bit;
    end else begin
      floor_nxt  = asbp_pkg::clamp10(fl);
      ceil_nxt   = asbp_pkg::clamp10(ce);
      center_nxt = asbp_pkg::clamp10(ctr);
      if (delta >= hy_w) begin
        bit_o = 1'b1;
      end else if (delta <= -hy_w) begin
        bit_o = 1'b0;
      end else begin
        bit_o = held_r;
      end
    end
    // Plain mode slices at midscale and leaves all tracking alone.
    if (!cfg.adaptive_mode) begin
      bit_o = plain_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= asbp_pkg::Midscale;
      floor_r  <= asbp_pkg::Midscale;
      ceil_r   <= asbp_pkg::Midscale;
      center_r <= asbp_pkg::Midscale;
      held_r   <= 1'b0;
      primed_r <= 1'b0;
    end else if (step && cfg.adaptive_mode) begin
      smooth_r <= smooth_nxt;
      floor_r  <= floor_nxt;
      ceil_r   <= ceil_nxt;
      center_r <= center_nxt;
      held_r   <= bit_o;
      primed_r <= 1'b1;
    end
  end

endmodule

[rtl/asbp_packer.sv]
// ---------------------------------------------------------------------------
// Bit packer
// Collects sliced bits MSB first and loads each full byte into the
// result register.
// ---------------------------------------------------------------------------
module asbp_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       bit_i,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [asbp_pkg::ByteW-1:0] out_tdata,
  output asbp_pkg::pk_stat_t         stat
);

  logic [asbp_pkg::ByteW-1:0] partial_r;
  logic [2:0]                 idx_r;
  logic [asbp_pkg::ByteW-1:0] data_r;
  logic                       valid_r;
  logic                       valid_nxt;
  logic [asbp_pkg::ByteW-1:0] byte_nxt;

  assign byte_nxt      = partial_r
                       | (asbp_pkg::ByteW'(bit_i) << (3'd7 - idx_r));
  assign stat.last_bit = (idx_r == 3'd7);
  assign stat.out_free = !valid_r || out_tready;
  assign out_tvalid    = valid_r;
  assign out_tdata     = data_r;

  // A new byte takes the result register; otherwise a taken beat empties it.
  assign valid_nxt = (step && stat.last_bit) || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      idx_r     <= '0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (step) begin
        if (stat.last_bit) begin
          partial_r <= '0;
        end else begin
          partial_r <= byte_nxt;
        end
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && stat.last_bit) begin
      data_r <= byte_nxt;
    end
  end

endmodule

[dv/adaptive_slicer_bit_packer_checker.sv]
// ---------------------------------------------------------------------------
// Adaptive slicer bit packer checker
// Watches the sample, byte and register channels. Each accepted sample goes
// through a local slicer and packer, and every completed byte is queued. Each
// byte beat from the block must match the oldest queued byte.
// ---------------------------------------------------------------------------
module adaptive_slicer_bit_packer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [9:0] sample, [15:10] zero
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [7:0]                    out_tdata,  // [7:0] data_byte
  input  logic                          cfg_we,
  input  logic [asbp_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [asbp_pkg::CfgDataW-1:0] cfg_wdata,
  output int unsigned                   bytes_due,
  output int unsigned                   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [asbp_pkg::ByteW-1:0] FirstBitMask = 8'h80;
  localparam int unsigned                ReportLimit  = 10;

  asbp_pkg::cfg_t                 settings;
  logic [asbp_pkg::SampleW-1:0]   lp_level;
  logic [asbp_pkg::SampleW-1:0]   floor_level;
  logic [asbp_pkg::SampleW-1:0]   ceil_level;
  logic [asbp_pkg::SampleW-1:0]   center;
  logic [asbp_pkg::HystW-1:0]     hyst_now;
  logic                           last_decision;
  logic                           tracking_primed;
  logic [asbp_pkg::ByteW-1:0]     shift_byte;
  logic [2:0]                     bit_pos;
  logic [asbp_pkg::ByteW-1:0]     pending_bytes [$];

  initial begin
    bytes_due  = 0;
    mismatches = 0;
  end

  function automatic logic [asbp_pkg::SampleW-1:0] sat10(input int v);
    if (v < 0) begin
      return '0;
    end else if (v > int'(asbp_pkg::SampleMax)) begin
      return asbp_pkg::SampleMax;
    end
    return v[asbp_pkg::SampleW-1:0];
  endfunction

  // Slices one sample to a bit and shifts it into the byte under assembly.
  function automatic void slice_and_pack(input logic [asbp_pkg::SampleW-1:0] smp);
    int   s;
    int   filt;
    int   fl;
    int   ce;
    int   span;
    int   tgt;
    int   ctr;
    int   delta;
    int   hw;
    logic decision;
    s = int'(smp);
    if (!settings.adaptive_mode) begin
      decision = (smp >= asbp_pkg::Midscale);
    end else begin
      filt = int'(lp_level) + ((s - int'(lp_level)) >>> settings.filter_shift);
      fl = int'(floor_level);
      ce = int'(ceil_level);
      decision = last_decision;
      if (!tracking_primed) begin
        fl = filt;
        ce = filt;
        hw = int'(settings.min_hysteresis);
        tracking_primed = 1'b1;
        center = filt[asbp_pkg::SampleW-1:0];
        decision = (smp >= asbp_pkg::Midscale);
      end else begin
        // Envelopes jump outward at once and creep back toward the filtered level.
        if (filt < fl) begin
          fl = filt;
        end else begin
          fl += (filt - fl) >>> settings.envelope_shift;
        end
        if (filt > ce) begin
          ce = filt;
        end else begin
          ce += (filt - ce) >>> settings.envelope_shift;
        end
        span = (ce >= fl) ? ce - fl : 0;
        hw = (span >> 7) & 255;
        // The lower clamp goes first, so the upper one wins when they cross.
        if (hw < int'(settings.min_hysteresis)) begin
          hw = int'(settings.min_hysteresis);
        end
        if (hw > int'(settings.max_hysteresis)) begin
          hw = int'(settings.max_hysteresis);
        end
        tgt = (fl + ce) >>> 1;
        ctr = int'(center) + ((tgt - int'(center)) >>> settings.center_shift);
        delta = s - ctr;
        if (delta >= hw) begin
          decision = 1'b1;
        end else if (delta <= -hw) begin
          decision = 1'b0;
        end
        center = sat10(ctr);
      end
      floor_level = sat10(fl);
      ceil_level = sat10(ce);
      lp_level = sat10(filt);
      hyst_now = hw[asbp_pkg::HystW-1:0];
      last_decision = decision;
    end

    if (decision) begin
      shift_byte |= FirstBitMask >> bit_pos;
    end
    if (bit_pos == 3'd7) begin
      pending_bytes.push_back(shift_byte);
      shift_byte = '0;
    end
    bit_pos = bit_pos + 3'd1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      settings        = '{1'b0, 4'd2, 4'd6, 4'd4, 8'd4, 8'd32};
      lp_level        = asbp_pkg::Midscale;
      floor_level     = asbp_pkg::Midscale;
      ceil_level      = asbp_pkg::Midscale;
      center          = asbp_pkg::Midscale;
      hyst_now        = 8'd8;
      last_decision   = 1'b0;
      tracking_primed = 1'b0;
      shift_byte      = '0;
      bit_pos         = '0;
      pending_bytes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_bytes.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("%0t: unexpected byte beat %02h with no byte pending", $realtime,
                     out_tdata);
          end
          mismatches <= mismatches + 1;
        end else begin
          if (out_tdata !== pending_bytes[0]) begin
            if (mismatches < ReportLimit) begin
              $display("%0t: data_byte mismatch: expected %02h, got %02h", $realtime,
                       pending_bytes[0], out_tdata);
            end
            mismatches <= mismatches + 1;
          end
          void'(pending_bytes.pop_front());
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          asbp_pkg::RegAdaptiveMode:
            settings.adaptive_mode  = cfg_wdata[0];
          asbp_pkg::RegFilterShift:
            settings.filter_shift   = cfg_wdata[asbp_pkg::ShiftW-1:0];
          asbp_pkg::RegEnvelopeShift:
            settings.envelope_shift = cfg_wdata[asbp_pkg::ShiftW-1:0];
          asbp_pkg::RegCenterShift:
            settings.center_shift   = cfg_wdata[asbp_pkg::ShiftW-1:0];
          asbp_pkg::RegMinHyst:
            settings.min_hysteresis = cfg_wdata[asbp_pkg::HystW-1:0];
          asbp_pkg::RegMaxHyst:
            settings.max_hysteresis = cfg_wdata[asbp_pkg::HystW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        slice_and_pack(in_tdata[asbp_pkg::SampleW-1:0]);
      end
    end
    bytes_due <= pending_bytes.size();
  end

endmodule

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// Adaptive slicer bit packer testbench
// Drives tape samples and register writes into the core, with random gaps on
// the sample side and random back-pressure on the byte side. A directed part
// covers plain mode, priming and zero hysteresis; random phases then run
// square-wave bursts, noise and rail-to-rail runs under changing settings.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [asbp_pkg::CfgAddrW-1:0] UnusedRegLo = 3'd6;
  localparam logic [asbp_pkg::CfgAddrW-1:0] UnusedRegHi = 3'd7;
  localparam int unsigned NumPhases   = 9;
  localparam int unsigned PhaseItems  = 55;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned HoldAfter   = 150;
  localparam int unsigned CycleLimit  = 200000;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [15:0]                   in_tdata   = '0;   // [9:0] sample, [15:10] zero
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [7:0]                    out_tdata;         // [7:0] data_byte
  logic                          cfg_we     = 1'b0;
  logic [asbp_pkg::CfgAddrW-1:0] cfg_addr   = '0;
  logic [asbp_pkg::CfgDataW-1:0] cfg_wdata  = '0;

  int unsigned bytes_due;
  int unsigned mismatches;
  int unsigned samples_sent = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned cycles       = 0;
  bit          hold_done    = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  adaptive_slicer_bit_packer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  adaptive_slicer_bit_packer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .bytes_due  (bytes_due),
    .mismatches (mismatches)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Byte side: random stalls, plus one long hold-off that backs up the sample side.
  initial begin
    forever begin
      if (!hold_done && samples_sent >= HoldAfter) begin
        out_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic [asbp_pkg::SampleW-1:0] smp);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, smp};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Waits until every byte is out and the pipeline holds no sample.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [asbp_pkg::CfgAddrW-1:0] addr,
                         input logic [asbp_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Unused upper bits of the mode and shift writes carry random junk that the block must drop.
  task automatic apply_settings(input asbp_pkg::cfg_t c);
    put_reg(asbp_pkg::RegAdaptiveMode,  {7'($urandom_range(0, 127)), c.adaptive_mode});
    put_reg(asbp_pkg::RegFilterShift,   {4'($urandom_range(0, 15)), c.filter_shift});
    put_reg(asbp_pkg::RegEnvelopeShift, {4'($urandom_range(0, 15)), c.envelope_shift});
    put_reg(asbp_pkg::RegCenterShift,   {4'($urandom_range(0, 15)), c.center_shift});
    put_reg(asbp_pkg::RegMinHyst,       c.min_hysteresis);
    put_reg(asbp_pkg::RegMaxHyst,       c.max_hysteresis);
    cfg_we <= 1'b0;
  endtask

  // Mostly noisy square waves, as a tape would deliver, with some pure noise
  // and rail-to-rail runs mixed in.
  task automatic run_phase(input int unsigned n_items);
    int unsigned kind;
    int unsigned lo;
    int unsigned hi;
    int unsigned half;
    int unsigned noise;
    int unsigned seg_left;
    int unsigned pos;
    int          val;
    seg_left = 0;
    kind = 0;
    lo = 0;
    hi = 0;
    half = 1;
    noise = 0;
    pos = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (seg_left == 0) begin
        kind     = $urandom_range(0, 9);
        lo       = $urandom_range(0, 511);
        hi       = $urandom_range(512, 1023);
        half     = $urandom_range(1, 12);
        noise    = $urandom_range(0, 40);
        seg_left = $urandom_range(8, 60);
        pos      = 0;
      end
      if (kind < 7) begin
        val = ((pos / half) % 2 == 0) ? int'(hi) : int'(lo);
        val = val + int'($urandom_range(0, 2 * noise)) - int'(noise);
      end else if (kind < 9) begin
        val = int'($urandom_range(0, 1023));
      end else begin
        val = ($urandom_range(0, 1) == 1) ? int'(asbp_pkg::SampleMax) : 0;
      end
      if (val < 0) begin
        val = 0;
      end else if (val > int'(asbp_pkg::SampleMax)) begin
        val = int'(asbp_pkg::SampleMax);
      end
      send_sample(val[asbp_pkg::SampleW-1:0]);
      pos++;
      seg_left--;
    end
  endtask

  initial begin
    logic [asbp_pkg::SampleW-1:0] probe [$];
    asbp_pkg::cfg_t               s;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct  = 25;
    rx_stall_pct = 25;

    // Plain mode from reset: midscale threshold only, packs to 8'h55.
    probe = '{10'd0, 10'd1023, 10'd511, 10'd512, 10'h155, 10'h2AA, 10'd1, 10'd1022};
    foreach (probe[i]) send_sample(probe[i]);
    settle();

    // Adaptive with default tuning: the first sample primes the trackers.
    apply_settings('{1'b1, 4'd2, 4'd6, 4'd4, 8'd4, 8'd32});
    probe = '{10'd512, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd700, 10'd300, 10'd512};
    foreach (probe[i]) send_sample(probe[i]);
    settle();

    // No filtering and zero hysteresis: the sample sits on the center every time.
    apply_settings('{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 8'd0});
    probe = '{10'd0, 10'd1023, 10'd400, 10'd600, 10'd512, 10'd1, 10'd1022, 10'd777};
    foreach (probe[i]) send_sample(probe[i]);
    settle();

    put_reg(UnusedRegLo, 8'($urandom_range(0, 255)));
    put_reg(UnusedRegHi, 8'($urandom_range(0, 255)));

    for (int unsigned p = 0; p < NumPhases; p++) begin
      s.adaptive_mode  = ($urandom_range(0, 4) != 0);
      s.filter_shift   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 6));
      s.envelope_shift = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 6));
      s.center_shift   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 6));
      s.min_hysteresis = 8'($urandom_range(0, 24));
      s.max_hysteresis = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(4, 64));
      case (p)
        0: s = '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 8'd255};
        // Crossed clamps and shifts past the documented range.
        1: s = '{1'b1, 4'd15, 4'd15, 4'd15, 8'd255, 8'd0};
        2: s = '{1'b1, 4'd10, 4'd10, 4'd10, 8'd4, 8'd32};
        3: s.adaptive_mode = 1'b0;
        4: begin
          s.min_hysteresis = 8'd255;
          s.max_hysteresis = 8'd255;
        end
        default: ;
      endcase
      if (p == NumPhases - 1) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end else if (p == 2) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 20;
      end else begin
        tx_idle_pct  = 15 * $urandom_range(0, 2);
        rx_stall_pct = 20 * $urandom_range(0, 2);
      end
      apply_settings(s);
      run_phase(PhaseItems);
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
